/* rtl/core/utfd_pkg.sv */
`default_nettype none
package utfd_pkg;

  localparam int CP_W   = 31;
  localparam int BYTE_W = 8;
  localparam int REM_W  = 3;

  // result queue between the decoder and the output side
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic [CP_W-1:0]  acc;
    logic [REM_W-1:0] rem;
    logic             pend;
  } dec_state_t;

  typedef struct packed {
    dec_state_t nxt;
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage
`default_nettype wire

/* rtl/core/utfd_step.sv */
`default_nettype none
module utfd_step (
  input  wire logic [utfd_pkg::BYTE_W-1:0] byte_in,
  input  wire utfd_pkg::dec_state_t        cur,
  output utfd_pkg::step_t                  step
);
  import utfd_pkg::*;

  logic            is_cont;
  logic [CP_W-1:0] acc_shift;
  logic [REM_W-1:0] rem_dec;
  logic            byte_emit;
  logic            lead;
  logic [CP_W-1:0] lead_payload;
  logic [REM_W-1:0] lead_count;
  logic [CP_W-1:0] byte_val;

  assign is_cont   = (byte_in & CONT_MASK) == CONT_TAG;
  assign acc_shift = {cur.acc[CP_W-7:0], byte_in[5:0] & CONT_BITS[5:0]};
  assign rem_dec   = cur.rem - REM_W'(1);
  assign byte_val  = CP_W'(byte_in);

  always_comb begin
    lead         = 1'b0;
    byte_emit    = 1'b0;
    lead_payload = '0;
    lead_count   = '0;
    casez (byte_in)
      8'b0???????: byte_emit = (byte_in != '0);
      8'b10??????: byte_emit = 1'b1;
      8'b110?????: begin
        lead = 1'b1; lead_payload = CP_W'(byte_in[4:0]); lead_count = REM_W'(1);
      end
      8'b1110????: begin
        lead = 1'b1; lead_payload = CP_W'(byte_in[3:0]); lead_count = REM_W'(2);
      end
      8'b11110???: begin
        lead = 1'b1; lead_payload = CP_W'(byte_in[2:0]); lead_count = REM_W'(3);
      end
      8'b111110??: begin
        lead = 1'b1; lead_payload = CP_W'(byte_in[1:0]); lead_count = REM_W'(4);
      end
      8'b1111110?: begin
        lead = 1'b1; lead_payload = CP_W'(byte_in[0]); lead_count = REM_W'(5);
      end
      default: byte_emit = 1'b1;  // 0xFE, 0xFF pass through
    endcase
  end

  always_comb begin
    step = '0;
    if (cur.pend && is_cont) begin
      if (rem_dec == '0) begin
        step.nxt  = '0;
        step.n    = 2'd1;
        step.res0 = '{code_point: acc_shift, last_of_run: 1'b1};
      end else begin
        step.nxt.acc  = acc_shift;
        step.nxt.rem  = rem_dec;
        step.nxt.pend = 1'b1;
      end
    end else begin
      // state after a cut-short flush is idle; a lead byte reopens it
      if (lead) begin
        step.nxt.acc  = lead_payload;
        step.nxt.rem  = lead_count;
        step.nxt.pend = 1'b1;
      end
      if (cur.pend && byte_emit) begin
        step.n    = 2'd2;
        step.res0 = '{code_point: cur.acc, last_of_run: 1'b0};
        step.res1 = '{code_point: byte_val, last_of_run: 1'b1};
      end else if (cur.pend) begin
        step.n    = 2'd1;
        step.res0 = '{code_point: cur.acc, last_of_run: 1'b1};
      end else if (byte_emit) begin
        step.n    = 2'd1;
        step.res0 = '{code_point: byte_val, last_of_run: 1'b1};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/utf8_stream_decoder_unit.sv */
`default_nettype none
// channel   dir  signals                      payload
// s_*       in   s_tvalid s_tready s_tdata    byte_in
// m_*       out  m_tvalid m_tready m_tdata    code_point, last_of_run on m_tlast
//
// One byte is taken per cycle while s_tready is high; the decode step is
// combinational into a four-entry result queue, which also holds the output
// word shown on m_*. A byte that cuts a sequence short can yield two results,
// so the output side drains at one result per cycle while m_tready is high and the queue absorbs the extra entry.
// s_tready is high while the queue has room for two results.
// Reset (rst, synchronous) empties the queue and closes any open sequence.
module utf8_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [30:0] code_point, [31] zero
  output logic             m_tlast    // last_of_run
);
  import utfd_pkg::*;

  dec_state_t         st;
  step_t              step;
  result_t            q [QDEPTH];
  logic [QPTR_W-1:0]  wr;
  logic [QPTR_W-1:0]  rd;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;
  logic [QCNT_W-1:0]  push;
  logic               s_acc;
  logic               pop;

  utfd_step u_step (
    .byte_in (s_tdata[BYTE_W-1:0]),
    .cur     (st),
    .step    (step)
  );

  assign s_tready = count <= QCNT_W'(QDEPTH - 2);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign push     = s_acc ? QCNT_W'(step.n) : '0;
  assign count_next = count + push - QCNT_W'(pop);

  assign m_tdata = {1'b0, q[rd].code_point};
  assign m_tlast = q[rd].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (s_acc) begin
        st <= step.nxt;
        wr <= wr + QPTR_W'(step.n);
      end
      if (pop) begin
        rd <= rd + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // payload entries, no reset
  always_ff @(posedge clk) begin
    if (s_acc && step.n != 2'd0) begin
      q[wr] <= step.res0;
    end
    if (s_acc && step.n == 2'd2) begin
      q[wr + QPTR_W'(1)] <= step.res1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_open_has_rem: assert property (@(posedge clk) disable iff (rst)
    st.pend |-> st.rem != '0)
    else $error("open sequence with no bytes remaining");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (s_acc && step.n == 2'd2) |-> (!step.res0.last_of_run && step.res1.last_of_run))
    else $error("last flag misplaced on a two-result request");

  a_quiet_step: assert property (@(posedge clk) disable iff (rst)
    (s_acc && step.n == 2'd0 && !pop) |=> $stable(count))
    else $error("queue changed on a request with no result");

endmodule
`default_nettype wire
